// ===== rtl/sha1_pkg.sv =====
// Package with the shared types, constants and round function of the SHA-1 digest block.
package sha1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  localparam int BLOCK_BYTES = 64;
  localparam int LEN_SLOT    = 56;
  localparam int ROUNDS      = 80;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Round function for one of the four 20-round stages.
  function automatic logic [31:0] round_f(input logic [1:0] stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (stage)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/sha1_message_digest.sv =====
// SHA-1 message digest engine that takes one message byte per word and runs one round per cycle.
//
// A byte that completes a 64-byte block holds tready low through the 80 rounds and the
// hash update. An end of message pads one byte per cycle and runs one or two compressions;
// after a length overflow it goes straight to the error result. tvalid is held back while
// the previous digest still waits for the receiver.
// Reset (rst, synchronous, active high) loads the initial hash words and clears all counts.
module sha1_message_digest
  import sha1_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Input stream: one optional message byte per word.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] byte_present
  input  logic         s_axis_tlast,   // end_of_message
  // Output stream: one digest word per message.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // [31:0] digest_word0 .. [159:128] digest_word4
  output logic         m_axis_tuser    // [0] length_error
);

  // Sequencer state.
  state_t state, state_next;

  // The message block is a 512-bit shift line. Bytes enter at the bottom, so after
  // 64 bytes the first message word sits at the top. During compression the line
  // shifts by one 32-bit word per round and the expanded schedule word enters at
  // the bottom, which leaves the four schedule taps at fixed places.
  logic [511:0] blk;
  logic [6:0]   fill;        // bytes held in the line, 0 to 64
  logic [63:0]  bit_count;
  logic         ovf;         // the bit count has wrapped
  logic         end_pend;    // an end of message is being worked off
  logic         mark_done;   // the 0x80 marker byte is already in the line
  logic         last_blk;    // the block in flight carries the length
  logic [6:0]   rnd;

  logic [31:0] hash [5];
  logic [31:0] a, b, c, d, e;

  // Output register: a finished digest waits here while the next message streams in.
  logic         out_valid;
  logic [159:0] digest;
  logic         length_err;

  // Control strobes from the output decode.
  logic take, byte_take, wrap, emit_go, round_start;

  // Round datapath.
  logic [1:0]  stage;
  logic [31:0] w_cur, w_new, w_mix, f_val, temp;

  assign w_cur = blk[511:480];
  assign w_mix = blk[511:480] ^ blk[447:416] ^ blk[255:224] ^ blk[95:64];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (rnd < 7'd20) begin
      stage = 2'd0;
    end else if (rnd < 7'd40) begin
      stage = 2'd1;
    end else if (rnd < 7'd60) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
  end

  assign f_val = round_f(stage, b, c, d);
  assign temp  = {a[26:0], a[31:27]} + f_val + e + w_cur + ROUND_K[stage];

  // Adding eight bits wraps the 64-bit count exactly when bits 63:3 are all ones.
  assign wrap = &bit_count[63:3];

  // Output decode: handshake and strobes.
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !rst;
    take          = s_axis_tvalid && s_axis_tready;
    byte_take     = take && s_axis_tuser && !ovf;
    emit_go       = (state == ST_EMIT) && (!out_valid || m_axis_tready);
    round_start   = (state != ST_ROUND) && (state_next == ST_ROUND);
  end

  // Next-state decode.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          priority if (byte_take && fill == 7'(BLOCK_BYTES - 1)) begin
            state_next = ST_ROUND;
          end else if (s_axis_tlast) begin
            // A byte that wraps the count ends the message in error as well.
            state_next = (ovf || (byte_take && wrap)) ? ST_EMIT : ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (fill == 7'(BLOCK_BYTES) || (mark_done && fill == 7'(LEN_SLOT))) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 7'(ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        priority if (last_blk) begin
          state_next = ST_EMIT;
        end else if (end_pend) begin
          state_next = ovf ? ST_EMIT : ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bit_count <= '0;
      ovf       <= 1'b0;
      end_pend  <= 1'b0;
      mark_done <= 1'b0;
      last_blk  <= 1'b0;
      rnd       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        hash[i] <= H_INIT[i];
      end
    end else begin
      state <= state_next;

      if (m_axis_tvalid && m_axis_tready && !emit_go) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (byte_take) begin
            fill      <= fill + 7'd1;
            bit_count <= bit_count + 64'd8;
            if (wrap) begin
              ovf <= 1'b1;
            end
          end
          if (take && s_axis_tlast) begin
            end_pend  <= 1'b1;
            mark_done <= 1'b0;
          end
        end
        ST_PAD: begin
          if (fill != 7'(BLOCK_BYTES)) begin
            if (mark_done && fill == 7'(LEN_SLOT)) begin
              fill     <= 7'(BLOCK_BYTES);
              last_blk <= 1'b1;
            end else begin
              fill      <= fill + 7'd1;
              mark_done <= 1'b1;
            end
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 7'd1;
        end
        ST_FINAL: begin
          rnd  <= '0;
          fill <= '0;
          hash[0] <= hash[0] + a;
          hash[1] <= hash[1] + b;
          hash[2] <= hash[2] + c;
          hash[3] <= hash[3] + d;
          hash[4] <= hash[4] + e;
        end
        ST_EMIT: begin
          // The digest leaves for the output register and the engine starts over.
          if (emit_go) begin
            out_valid <= 1'b1;
            fill      <= '0;
            bit_count <= '0;
            ovf       <= 1'b0;
            end_pend  <= 1'b0;
            mark_done <= 1'b0;
            last_blk  <= 1'b0;
            for (int i = 0; i < 5; i++) begin
              hash[i] <= H_INIT[i];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Block shift line and working variables.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (byte_take) begin
          blk <= {blk[503:0], s_axis_tdata};
        end
      end
      ST_PAD: begin
        if (fill != 7'(BLOCK_BYTES)) begin
          priority if (!mark_done) begin
            blk <= {blk[503:0], PAD_BYTE};
          end else if (fill == 7'(LEN_SLOT)) begin
            // The big-endian bit length fills the last eight bytes at once.
            blk <= {blk[447:0], bit_count};
          end else begin
            blk <= {blk[503:0], 8'h00};
          end
        end
      end
      ST_ROUND: begin
        blk <= {blk[479:0], w_new};
      end
      default: begin
      end
    endcase

    if (round_start) begin
      a <= hash[0];
      b <= hash[1];
      c <= hash[2];
      d <= hash[3];
      e <= hash[4];
    end else if (state == ST_ROUND) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= temp;
    end
  end

  // Result payload: zero words and the error flag once the count has wrapped.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (ovf) begin
        digest     <= '0;
        length_err <= 1'b1;
      end else begin
        digest     <= {hash[4], hash[3], hash[2], hash[1], hash[0]};
        length_err <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = digest;
  assign m_axis_tuser  = length_err;

endmodule

// ===== tb/tb_sha1_message_digest.sv =====
// Self-checking testbench for the SHA-1 message digest block with a built-in SHA-1 predictor.
module tb_sha1_message_digest;
  timeunit 1ns;
  timeprecision 1ps;

  // Idling profiles. Each message carries one, so the profile changes every few messages
  // and gaps land on byte loading, block compression and padding alike.
  localparam logic [1:0] PH_STEADY    = 2'd0;  // no idling on either side
  localparam logic [1:0] PH_SLOW_SRC  = 2'd1;  // sender idles 47 percent of the time
  localparam logic [1:0] PH_SLOW_SINK = 2'd2;  // receiver stalls 47 percent of the time
  localparam logic [1:0] PH_BOTH      = 2'd3;  // both sides idle 10 percent of the time

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam int TARGET_WORDS = 1900;
  localparam int DRAIN_CYCLES = 300;
  localparam int SHOWN_ERRORS = 10;

  // One word offered on the input stream, plus the idling profile and an optional
  // hold that keeps it back until every pending digest has come out.
  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic [1:0] phase;
    logic       drain_first;
  } msg_word_t;

  // Expected digest: h[i] lands at m_axis_tdata[32*i +: 32].
  typedef struct packed {
    logic             err;
    logic [4:0][31:0] h;
  } digest_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic         s_axis_tuser = 1'b0;    // [0] byte_present
  logic         s_axis_tlast = 1'b0;    // end_of_message
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;           // [31:0] digest_word0 .. [159:128] digest_word4
  logic         m_axis_tuser;           // [0] length_error

  sha1_message_digest dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // SHA-1 predictor: its own copy of the pending block, chaining words, byte fill,
  // message bit count and the overflow flag.
  // ---------------------------------------------------------------------------
  logic [7:0]  msg_block [64];
  logic [31:0] chain [5];
  int          fill;
  logic [63:0] bits_seen;
  logic        count_wrapped;

  msg_word_t   word_queue [$];   // words waiting to be offered
  digest_t     digest_due [$];   // digests predicted but not yet seen
  msg_word_t   on_bus;           // word currently offered on the input stream
  logic [1:0]  sink_phase = PH_STEADY;
  int          errors = 0;

  function automatic void sha1_restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    chain[4] = 32'hc3d2e1f0;
    fill = 0;
    bits_seen = '0;
    count_wrapped = 1'b0;
  endfunction

  // 80-round compression of msg_block into the chaining words.
  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = {a[26:0], a[31:27]} + f + e + w[i] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
    fill = 0;
  endfunction

  // Applies one accepted word and queues the digest it produces, if any.
  function automatic void absorb_word(msg_word_t wd);
    digest_t r;
    if (wd.present && !count_wrapped) begin
      msg_block[fill] = wd.data;
      fill++;
      bits_seen += 64'd8;
      // Once the count wraps, later bytes are dropped until the end of the message.
      if (bits_seen == '0) count_wrapped = 1'b1;
      if (fill == 64) sha1_compress();
    end
    if (!wd.eom) return;
    if (count_wrapped) begin
      r.h = '0;
      r.err = 1'b1;
    end else begin
      // Padding: marker byte, zeros, then the 64-bit big-endian bit length.
      // With more than 55 bytes pending the length does not fit, so a second block follows.
      msg_block[fill] = PAD_MARK;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin
          msg_block[fill] = 8'h00;
          fill++;
        end
        sha1_compress();
      end
      while (fill < 56) begin
        msg_block[fill] = 8'h00;
        fill++;
      end
      for (int i = 0; i < 8; i++)
        msg_block[56+i] = bits_seen[63-8*i -: 8];
      sha1_compress();
      for (int i = 0; i < 5; i++)
        r.h[i] = chain[i];
      r.err = 1'b0;
    end
    digest_due.push_back(r);
    sha1_restart();
  endfunction

  function automatic int sender_gap_pct(logic [1:0] ph);
    case (ph)
      PH_SLOW_SRC: return 47;
      PH_BOTH:     return 10;
      default:     return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(logic [1:0] ph);
    case (ph)
      PH_SLOW_SINK: return 47;
      PH_BOTH:      return 10;
      default:      return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. On each edge it first books the word that was just accepted with the
  // predictor, then decides whether to offer the next one. tvalid gets at most one
  // assignment per edge, so a word that follows straight on keeps it high.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_word(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        // A held word waits until the output side has delivered everything.
        if (word_queue.size() != 0 &&
            !(word_queue[0].drain_first && digest_due.size() != 0) &&
            $urandom_range(0, 99) >= sender_gap_pct(word_queue[0].phase)) begin
          on_bus = word_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.data;
          s_axis_tuser  <= on_bus.present;
          s_axis_tlast  <= on_bus.eom;
          sink_phase    <= on_bus.phase;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= SHOWN_ERRORS)
      $display("%0t: %s mismatch: expected %08h, got %08h", $realtime, field, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor. Random backpressure on tready; every accepted digest word is checked
  // field by field against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : digest_monitor
    digest_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct(sink_phase));
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_due.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("%0t: digest word with no message pending: %h", $realtime, m_axis_tdata);
        end else begin
          want = digest_due.pop_front();
          for (int i = 0; i < 5; i++)
            if (m_axis_tdata[32*i +: 32] !== want.h[i])
              flag_mismatch($sformatf("digest_word%0d", i), want.h[i], m_axis_tdata[32*i +: 32]);
          if (m_axis_tuser !== want.err)
            flag_mismatch("length_error", {31'd0, want.err}, {31'd0, m_axis_tuser});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Message lengths around the padding and block boundaries: 55 bytes still leave
  // room for the length, 56 forces a second padding block, 64 fills a block exactly.
  int boundary_len [13] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 121, 128};
  int live_words = 0;   // words that carry a byte or an end; ignored words do not count

  task automatic add_word(logic [7:0] data, logic present, logic eom,
                          logic [1:0] phase, logic hold = 1'b0);
    msg_word_t wd;
    wd.data = data;
    wd.present = present;
    wd.eom = eom;
    wd.phase = phase;
    wd.drain_first = hold;
    word_queue.push_back(wd);
    if (present || eom) live_words++;
  endtask

  // Random-content message. The end rides on the last byte or on a word of its own,
  // and now and then an empty word without end is slipped in as noise.
  task automatic add_message(int len, logic [1:0] phase, logic hold);
    logic end_on_byte;
    end_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5)
        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, phase, hold && i == 0);
      add_word(8'($urandom_range(0, 255)), 1'b1, end_on_byte && i == len - 1, phase,
               hold && i == 0);
    end
    if (!end_on_byte)
      add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, phase, hold && len == 0);
  endtask

  initial begin
    int n_msgs;
    int len;
    logic [1:0] ph;

    sha1_restart();

    // Directed opening, no idling.
    add_word(8'hff, 1'b0, 1'b0, PH_STEADY);     // empty word before anything: ignored
    add_word(8'hff, 1'b0, 1'b1, PH_STEADY);     // empty message
    add_word(8'h61, 1'b1, 1'b0, PH_STEADY);     // "abc", end on the last byte
    add_word(8'h62, 1'b1, 1'b0, PH_STEADY);
    add_word(8'h63, 1'b1, 1'b1, PH_STEADY);
    add_word(8'h00, 1'b1, 1'b0, PH_STEADY);     // single zero byte, separate end
    add_word(8'h00, 1'b0, 1'b1, PH_STEADY);
    add_word(8'hff, 1'b1, 1'b1, PH_STEADY);     // single all-ones byte with end
    add_word(8'h5a, 1'b1, 1'b0, PH_STEADY);     // ignored word inside a message
    add_word(8'hc3, 1'b0, 1'b0, PH_STEADY);
    add_word(8'ha5, 1'b1, 1'b0, PH_STEADY);
    add_word(8'h3c, 1'b0, 1'b1, PH_STEADY);
    add_word(8'h00, 1'b0, 1'b1, PH_STEADY);     // second empty message right after
    add_word(8'h7e, 1'b0, 1'b0, PH_STEADY);

    // Random messages. The profile moves on every four messages; every tenth message
    // holds its first word until all earlier digests are out.
    n_msgs = 0;
    while (live_words < TARGET_WORDS) begin
      ph = 2'((n_msgs / 4) % 4);
      if (n_msgs % 17 == 16)
        len = $urandom_range(150, 400);
      else if ($urandom_range(0, 1))
        len = boundary_len[$urandom_range(0, 12)];
      else
        len = $urandom_range(0, 140);
      add_message(len, ph, n_msgs % 10 == 0);
      n_msgs++;
    end
  end

  // Reset, then wait for the queue to run dry and every digest to arrive.
  // The checks run at the falling edge, once the driver's updates have settled.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (word_queue.size() != 0 || s_axis_tvalid || digest_due.size() != 0)
      @(negedge clk);
    // A late or extra digest word would still show up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
